// ===== rtl/ssd_pkg.sv =====
// Shared types, constants and the character decoder of the seven segment text driver.
// No dependencies; every other file of the block imports this package.
package ssd_pkg;

   // Display geometry
   localparam int DIGIT_COUNT = 2;
   localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int CNT_W       = $clog2(DIGIT_COUNT + 1);
   localparam int SEG_W       = 7;

   // Queue depths between front, back and the result port
   localparam int CMD_DEPTH    = 2;
   localparam int CMD_PTR_W    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
   localparam int CMD_CNT_W    = $clog2(CMD_DEPTH + 1);
   localparam int RES_DEPTH    = 2;
   localparam int RES_PTR_W    = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
   localparam int RES_CNT_W    = $clog2(RES_DEPTH + 1);

   // Configuration register indexes
   localparam logic CSR_SEG_LEVEL   = 1'b0;
   localparam logic CSR_DIGIT_LEVEL = 1'b1;

   // Input item kinds
   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_SCAN = 1'b1;

   // Result kinds and write status codes
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_SCAN  = 1'b1;
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Command codes passed from front to back
   localparam logic [2:0] OP_SCAN  = 3'd0;
   localparam logic [2:0] OP_GLYPH = 3'd1;
   localparam logic [2:0] OP_DOT   = 3'd2;
   localparam logic [2:0] OP_END   = 3'd3;
   localparam logic [2:0] OP_BAD   = 3'd4;

   // Special characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Segment patterns: digits 0..9, minus, blank
   localparam logic [SEG_W-1:0] GLYPH_TABLE [12] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F, 7'h40, 7'h00
   };
   localparam int GLYPH_MINUS = 10;
   localparam int GLYPH_BLANK = 11;

   typedef struct packed {
      logic seg_level;
      logic digit_level;
   } ssd_cfg_type;

   typedef struct packed {
      logic [2:0]       op;
      logic [SEG_W-1:0] glyph;
   } ssd_cmd_type;

   typedef struct packed {
      logic                   kind;
      logic                   status;
      logic [SEG_W-1:0]       seg;
      logic                   dp;
      logic [DIGIT_COUNT-1:0] dig;
   } ssd_res_type;

   // Classify one input item into a back-end command
   function automatic ssd_cmd_type classify(input logic func, input logic [7:0] c);
      ssd_cmd_type cmd;
      cmd.op    = OP_BAD;
      cmd.glyph = '0;
      if (func == FUNC_SCAN) begin
         cmd.op = OP_SCAN;
      end else if (c == CHAR_NUL) begin
         cmd.op = OP_END;
      end else if (c == CHAR_DOT) begin
         cmd.op = OP_DOT;
      end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
         cmd.op    = OP_GLYPH;
         cmd.glyph = GLYPH_TABLE[c[3:0]];
      end else if (c == CHAR_MINUS) begin
         cmd.op    = OP_GLYPH;
         cmd.glyph = GLYPH_TABLE[GLYPH_MINUS];
      end else if (c == CHAR_SPACE) begin
         cmd.op    = OP_GLYPH;
         cmd.glyph = GLYPH_TABLE[GLYPH_BLANK];
      end
      return cmd;
   endfunction

endpackage

// ===== rtl/seven_segment_text_mux_driver.sv =====
// Top level of the multiplexed seven segment text driver: configuration registers,
// front decoder, command queue and back end. Depends on ssd_pkg and the ssd_* modules.
//
// Usage:
// - Input queue: drive push with req_func / req_char_code; a transaction is taken at a
//   rising edge with push high and full low. req_func 0 sends one character of a
//   NUL-ended string, req_func 1 is a scan tick.
// - Result queue: while empty is low the oldest result sits on the rsp_ ports; pop
//   with empty low takes it. A scan tick yields the drive levels of the next digit.
//   A string end gives a write-finished result unless an unknown character came first,
//   which yields one itself if the buffer has room. Other characters yield no result.
// - Configuration: csr_write with csr_index 0 sets the segment active level, index 1
//   the digit active level. Write only while the block is idle.
// - Throughput: one transaction per cycle, sustained as long as pop keeps up.
// - Path: an input transaction is registered in the command queue, its result in the
//   result queue, from whose head it shows on the result ports until it is popped.
// - Stall: when pop stays low the two-entry result queue fills, the back end holds,
//   the two-entry command queue fills and full rises; nothing is dropped.
// - Reset: synchronous; clears both queues, blanks display and staging buffer, sets
//   the segment level to 1 and the digit level to 0.
module seven_segment_text_mux_driver import ssd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic                   req_func,
   input  logic [7:0]             req_char_code,
   output logic                   empty,
   input  logic                   pop,
   output logic                   rsp_result_kind,
   output logic                   rsp_write_status,
   output logic [SEG_W-1:0]       rsp_segment_lines,
   output logic                   rsp_decimal_point_line,
   output logic [DIGIT_COUNT-1:0] rsp_digit_lines,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic                   csr_data
);

   ssd_cfg_type cfg_ff, cfg_in;
   ssd_cmd_type front_cmd;
   ssd_cmd_type queued_cmd;
   logic        cmd_valid;
   logic        cmd_pop;
   logic        res_valid;
   ssd_res_type res;

   // Update configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_SEG_LEVEL:   cfg_in.seg_level   = csr_data;
            CSR_DIGIT_LEVEL: cfg_in.digit_level = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seg_level   <= 1'b1;
         cfg_ff.digit_level <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssd_front u_front (
      .func      (req_func),
      .char_code (req_char_code),
      .cmd       (front_cmd)
   );

   ssd_cmd_fifo u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (front_cmd),
      .full  (full),
      .valid (cmd_valid),
      .pop   (cmd_pop),
      .dout  (queued_cmd)
   );

   ssd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (queued_cmd),
      .cmd_pop   (cmd_pop),
      .res_pop   (pop),
      .res_valid (res_valid),
      .res       (res)
   );

   // Drive result ports from the queue head
   assign empty                  = !res_valid;
   assign rsp_result_kind        = res.kind;
   assign rsp_write_status       = res.status;
   assign rsp_segment_lines      = res.seg;
   assign rsp_decimal_point_line = res.dp;
   assign rsp_digit_lines        = res.dig;

   // Both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (empty && !cmd_valid))
      else $error("queues not empty after reset");

   // With the result queue empty the back end never holds a pending command
   a_back_drains: assert property (@(posedge clock) disable iff (reset)
      (empty && cmd_valid) |-> cmd_pop)
      else $error("back end stalled with room in result queue");

   // A write-finished result carries no drive levels
   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_kind == KIND_WRITE)) |->
         ((rsp_segment_lines == '0) && !rsp_decimal_point_line && (rsp_digit_lines == '0)))
      else $error("write result with nonzero drive fields");

   // A scan result always reports OK status
   a_scan_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_result_kind == KIND_SCAN)) |-> (rsp_write_status == STATUS_OK))
      else $error("scan result with error status");

endmodule

// ===== rtl/ssd_front.sv =====
// Front end: decodes each accepted input transaction into a command for the back end.
// Depends on ssd_pkg (command codes and glyph table).
module ssd_front import ssd_pkg::*; (
   input  logic        func,
   input  logic [7:0]  char_code,
   output ssd_cmd_type cmd
);

   // Decode the character or scan tick
   always_comb begin
      cmd = classify(func, char_code);
   end

endmodule

// ===== rtl/ssd_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on ssd_pkg (command type and queue depth).
module ssd_cmd_fifo import ssd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  ssd_cmd_type din,
   output logic        full,
   output logic        valid,
   input  logic        pop,
   output ssd_cmd_type dout
);

   ssd_cmd_type          mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0] wr_ff, wr_in;
   logic [CMD_PTR_W-1:0] rd_ff, rd_in;
   logic [CMD_CNT_W-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign dout    = mem_ff[rd_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ff + CMD_PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ff + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

// ===== rtl/ssd_back.sv =====
// Back end: staging buffer, committed display, scan position and the result queue.
// Depends on ssd_pkg (command and result types, glyph constants, depths).
module ssd_back import ssd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ssd_cfg_type cfg,
   input  logic        cmd_valid,
   input  ssd_cmd_type cmd,
   output logic        cmd_pop,
   input  logic        res_pop,
   output logic        res_valid,
   output ssd_res_type res
);

   logic [SEG_W-1:0]       shown_seg_ff [DIGIT_COUNT];
   logic [SEG_W-1:0]       shown_seg_in [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] shown_pt_ff, shown_pt_in;
   logic [SEG_W-1:0]       staged_seg_ff [DIGIT_COUNT];
   logic [SEG_W-1:0]       staged_seg_in [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] staged_pt_ff, staged_pt_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic                   skip_ff, skip_in;
   logic [POS_W-1:0]       scan_ff, scan_in;

   ssd_res_type            res_mem_ff [RES_DEPTH];
   logic [RES_PTR_W-1:0]   res_wr_ff, res_wr_in;
   logic [RES_PTR_W-1:0]   res_rd_ff, res_rd_in;
   logic [RES_CNT_W-1:0]   res_count_ff, res_count_in;
   logic                   res_push, res_take;
   ssd_res_type            res_new;

   logic [SEG_W-1:0]       just_seg [DIGIT_COUNT];
   logic [DIGIT_COUNT-1:0] just_pt;
   logic [CNT_W-1:0]       shift;
   logic [CNT_W-1:0]       fill_dec;
   logic                   has_room;
   logic [DIGIT_COUNT-1:0] dig_hot;

   assign res_valid = (res_count_ff != '0);
   assign res_take  = res_pop && res_valid;
   assign res       = res_mem_ff[res_rd_ff];
   assign has_room  = (fill_ff < CNT_W'(DIGIT_COUNT));
   assign fill_dec  = fill_ff - CNT_W'(1);
   assign dig_hot   = DIGIT_COUNT'(1) << scan_ff;

   // Execute a command when the result queue has a slot or frees one now
   assign cmd_pop = cmd_valid && ((res_count_ff != RES_CNT_W'(RES_DEPTH)) || res_take);

   // Right-justify the staged text, blanks on the left
   always_comb begin
      int src;
      shift = CNT_W'(DIGIT_COUNT) - fill_ff;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         src         = i - int'(shift);
         just_seg[i] = '0;
         just_pt[i]  = 1'b0;
         if (src >= 0) begin
            just_seg[i] = staged_seg_ff[src[POS_W-1:0]];
            just_pt[i]  = staged_pt_ff[src[POS_W-1:0]];
         end
      end
   end

   // Carry out one command
   always_comb begin
      shown_seg_in  = shown_seg_ff;
      shown_pt_in   = shown_pt_ff;
      staged_seg_in = staged_seg_ff;
      staged_pt_in  = staged_pt_ff;
      fill_in       = fill_ff;
      skip_in       = skip_ff;
      scan_in       = scan_ff;
      res_push      = 1'b0;
      res_new       = '0;
      if (cmd_pop) begin
         case (cmd.op)
            OP_SCAN: begin
               res_push       = 1'b1;
               res_new.kind   = KIND_SCAN;
               res_new.status = STATUS_OK;
               res_new.seg    = shown_seg_ff[scan_ff] ^ {SEG_W{~cfg.seg_level}};
               res_new.dp     = shown_pt_ff[scan_ff] ^ ~cfg.seg_level;
               res_new.dig    = dig_hot ^ {DIGIT_COUNT{~cfg.digit_level}};
               scan_in = (scan_ff == POS_W'(DIGIT_COUNT - 1)) ? '0 : scan_ff + POS_W'(1);
            end
            OP_END: begin
               if (skip_ff) begin
                  skip_in = 1'b0;
               end else begin
                  shown_seg_in   = just_seg;
                  shown_pt_in    = just_pt;
                  res_push       = 1'b1;
                  res_new.kind   = KIND_WRITE;
                  res_new.status = STATUS_OK;
               end
               staged_seg_in = '{default: '0};
               staged_pt_in  = '0;
               fill_in       = '0;
            end
            OP_DOT: begin
               if (!skip_ff && has_room && (fill_ff != '0)) begin
                  staged_pt_in[fill_dec[POS_W-1:0]] = 1'b1;
               end
            end
            OP_GLYPH: begin
               if (!skip_ff && has_room) begin
                  staged_seg_in[fill_ff[POS_W-1:0]] = cmd.glyph;
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            OP_BAD: begin
               if (!skip_ff && has_room) begin
                  shown_seg_in   = staged_seg_ff;
                  shown_pt_in    = staged_pt_ff;
                  staged_seg_in  = '{default: '0};
                  staged_pt_in   = '0;
                  fill_in        = '0;
                  skip_in        = 1'b1;
                  res_push       = 1'b1;
                  res_new.kind   = KIND_WRITE;
                  res_new.status = STATUS_ERR;
               end
            end
            default: ;
         endcase
      end
   end

   // Advance result queue pointers and occupancy
   always_comb begin
      res_wr_in    = res_wr_ff;
      res_rd_in    = res_rd_ff;
      res_count_in = res_count_ff;
      if (res_push) begin
         res_wr_in = (res_wr_ff == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : res_wr_ff + RES_PTR_W'(1);
      end
      if (res_take) begin
         res_rd_in = (res_rd_ff == RES_PTR_W'(RES_DEPTH - 1)) ? '0 : res_rd_ff + RES_PTR_W'(1);
      end
      if (res_push && !res_take) begin
         res_count_in = res_count_ff + RES_CNT_W'(1);
      end else if (res_take && !res_push) begin
         res_count_in = res_count_ff - RES_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_seg_ff  <= '{default: '0};
         shown_pt_ff   <= '0;
         staged_seg_ff <= '{default: '0};
         staged_pt_ff  <= '0;
         fill_ff       <= '0;
         skip_ff       <= 1'b0;
         scan_ff       <= '0;
         res_wr_ff     <= '0;
         res_rd_ff     <= '0;
         res_count_ff  <= '0;
      end else begin
         shown_seg_ff  <= shown_seg_in;
         shown_pt_ff   <= shown_pt_in;
         staged_seg_ff <= staged_seg_in;
         staged_pt_ff  <= staged_pt_in;
         fill_ff       <= fill_in;
         skip_ff       <= skip_in;
         scan_ff       <= scan_in;
         res_wr_ff     <= res_wr_in;
         res_rd_ff     <= res_rd_in;
         res_count_ff  <= res_count_in;
      end
   end

   // Store the result entry
   always_ff @(posedge clock) begin
      if (res_push) begin
         res_mem_ff[res_wr_ff] <= res_new;
      end
   end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of seven_segment_text_mux_driver: strings and scan ticks are
// pushed with random gaps, results are popped with random stalls and checked against a
// shadow display kept by a small scoreboard class. Depends on rtl/ssd_pkg.sv and the RTL.
module testbench;
   import ssd_pkg::*;

   localparam int WATCHDOG_LIMIT = 400;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PHASE_ITEMS    = 360;

   // Segment shapes of the digits, minus and blank
   localparam logic [SEG_W-1:0] DIGIT_SHAPES [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };
   localparam logic [SEG_W-1:0] MINUS_SHAPE = 7'h40;
   localparam logic [SEG_W-1:0] BLANK_SHAPE = 7'h00;

   // Directed opening: {func, char}
   localparam logic [8:0] DIRECTED [27] = '{
      {FUNC_SCAN, 8'h00}, {FUNC_SCAN, 8'hFF},
      {FUNC_CHAR, CHAR_NINE}, {FUNC_CHAR, CHAR_DOT}, {FUNC_CHAR, CHAR_DOT},
      {FUNC_CHAR, CHAR_NUL}, {FUNC_SCAN, 8'h5A},
      {FUNC_CHAR, CHAR_DOT}, {FUNC_CHAR, CHAR_MINUS}, {FUNC_SCAN, 8'h00},
      {FUNC_CHAR, CHAR_ZERO}, {FUNC_CHAR, CHAR_ZERO + 8'd1}, {FUNC_CHAR, CHAR_DOT},
      {FUNC_CHAR, 8'hFF}, {FUNC_CHAR, CHAR_NUL}, {FUNC_SCAN, 8'h00},
      {FUNC_CHAR, CHAR_ZERO + 8'd3}, {FUNC_CHAR, 8'h80}, {FUNC_CHAR, CHAR_ZERO + 8'd5},
      {FUNC_CHAR, CHAR_NUL}, {FUNC_SCAN, 8'h00}, {FUNC_SCAN, 8'h00},
      {FUNC_CHAR, CHAR_NUL}, {FUNC_CHAR, CHAR_SPACE}, {FUNC_CHAR, CHAR_DOT},
      {FUNC_CHAR, CHAR_NUL}, {FUNC_SCAN, 8'h00}
   };

   // Shadow of the display state and queue of results still owed by the block
   class display_scoreboard;
      logic             seg_level;
      logic             digit_level;
      logic [SEG_W-1:0] shown_seg [DIGIT_COUNT];
      logic             shown_dp  [DIGIT_COUNT];
      logic [SEG_W-1:0] staged_seg [DIGIT_COUNT];
      logic             staged_dp  [DIGIT_COUNT];
      int               fill;
      bit               skipping;
      int               scan_pos;
      ssd_res_type      owed_results [$];
      int               errors;

      function new();
         seg_level   = 1'b1;
         digit_level = 1'b0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            shown_seg[i] = BLANK_SHAPE;
            shown_dp[i]  = 1'b0;
         end
         clear_staging();
         skipping = 0;
         scan_pos = 0;
         errors   = 0;
      endfunction

      function void clear_staging();
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            staged_seg[i] = BLANK_SHAPE;
            staged_dp[i]  = 1'b0;
         end
         fill = 0;
      endfunction

      function void commit_staging();
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            shown_seg[i] = staged_seg[i];
            shown_dp[i]  = staged_dp[i];
         end
      endfunction

      function void set_level(logic idx, logic val);
         if (idx == CSR_SEG_LEVEL) seg_level = val;
         else digit_level = val;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      function void owe_write(logic status);
         ssd_res_type r;
         r        = '0;
         r.kind   = KIND_WRITE;
         r.status = status;
         owed_results.push_back(r);
      endfunction

      // Advance the shadow by one accepted input transaction
      function void note_item(logic func, logic [7:0] c);
         ssd_res_type      r;
         logic [SEG_W-1:0] shape;
         int               gap;
         if (func == FUNC_SCAN) begin
            r.kind   = KIND_SCAN;
            r.status = STATUS_OK;
            r.seg    = shown_seg[scan_pos] ^ {SEG_W{~seg_level}};
            r.dp     = shown_dp[scan_pos] ^ ~seg_level;
            r.dig    = '0;
            r.dig[scan_pos] = 1'b1;
            if (!digit_level) r.dig = ~r.dig;
            owed_results.push_back(r);
            scan_pos = (scan_pos + 1) % DIGIT_COUNT;
            return;
         end
         // String end: right-justify and commit, or just leave skip mode
         if (c == CHAR_NUL) begin
            if (skipping) begin
               skipping = 0;
               clear_staging();
               return;
            end
            gap = DIGIT_COUNT - fill;
            for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
               if (i >= gap) begin
                  staged_seg[i] = staged_seg[i - gap];
                  staged_dp[i]  = staged_dp[i - gap];
               end else begin
                  staged_seg[i] = BLANK_SHAPE;
                  staged_dp[i]  = 1'b0;
               end
            end
            commit_staging();
            clear_staging();
            owe_write(STATUS_OK);
            return;
         end
         if (skipping || fill >= DIGIT_COUNT) return;
         if (c == CHAR_DOT) begin
            if (fill > 0) staged_dp[fill - 1] = 1'b1;
            return;
         end
         if (c >= CHAR_ZERO && c <= CHAR_NINE) shape = DIGIT_SHAPES[c - CHAR_ZERO];
         else if (c == CHAR_MINUS) shape = MINUS_SHAPE;
         else if (c == CHAR_SPACE) shape = BLANK_SHAPE;
         else begin
            // Unknown character: show the partial buffer as it is, then skip
            commit_staging();
            clear_staging();
            skipping = 1;
            owe_write(STATUS_ERR);
            return;
         end
         staged_seg[fill] = shape;
         fill++;
      endfunction

      // Compare one popped result with the oldest owed one
      function void check_result(ssd_res_type got);
         ssd_res_type want;
         if (owed_results.size() == 0) begin
            $error("unexpected result %h with nothing owed", got);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (got.kind !== want.kind) begin
            $error("rsp_result_kind: expected %0d, got %0d", want.kind, got.kind);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("rsp_write_status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.seg !== want.seg) begin
            $error("rsp_segment_lines: expected %h, got %h", want.seg, got.seg);
            errors++;
         end
         if (got.dp !== want.dp) begin
            $error("rsp_decimal_point_line: expected %0d, got %0d", want.dp, got.dp);
            errors++;
         end
         if (got.dig !== want.dig) begin
            $error("rsp_digit_lines: expected %b, got %b", want.dig, got.dig);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   push = 1'b0;
   logic                   full;
   logic                   req_func = FUNC_CHAR;
   logic [7:0]             req_char_code = CHAR_NUL;
   logic                   empty;
   logic                   pop = 1'b0;
   logic                   rsp_result_kind;
   logic                   rsp_write_status;
   logic [SEG_W-1:0]       rsp_segment_lines;
   logic                   rsp_decimal_point_line;
   logic [DIGIT_COUNT-1:0] rsp_digit_lines;
   logic                   csr_write = 1'b0;
   logic                   csr_index = CSR_SEG_LEVEL;
   logic                   csr_data = 1'b0;

   display_scoreboard shadow;
   ssd_res_type       popped;
   int                items_sent = 0;
   int                idle_cycles = 0;
   bit                tx_steady = 0;
   int                tx_steady_left = 0;
   bit                rx_steady = 0;
   int                rx_steady_left = 0;

   always #1 clock = ~clock;

   seven_segment_text_mux_driver dut (
      .clock                  (clock),
      .reset                  (reset),
      .push                   (push),
      .full                   (full),
      .req_func               (req_func),
      .req_char_code          (req_char_code),
      .empty                  (empty),
      .pop                    (pop),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_write_status       (rsp_write_status),
      .rsp_segment_lines      (rsp_segment_lines),
      .rsp_decimal_point_line (rsp_decimal_point_line),
      .rsp_digit_lines        (rsp_digit_lines),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   assign popped = {rsp_result_kind, rsp_write_status, rsp_segment_lines,
                    rsp_decimal_point_line, rsp_digit_lines};

   // Check popped results, note pushed items, guard against a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) shadow.check_result(popped);
         if (push && !full) shadow.note_item(req_func, req_char_code);
         if ((pop && !empty) || (push && !full) || csr_write) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Push one transaction after a random gap; return at the edge that takes it
   task automatic send_item(input logic func, input logic [7:0] c);
      int gap;
      if (tx_steady_left == 0) begin
         tx_steady      = ($urandom_range(0, 3) == 0);
         tx_steady_left = $urandom_range(20, 80);
      end
      tx_steady_left--;
      gap = tx_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push          <= 1'b1;
      req_func      <= func;
      req_char_code <= c;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   // Write both levels on back-to-back cycles
   task automatic write_levels(input logic seg, input logic dig);
      csr_write <= 1'b1;
      csr_index <= CSR_SEG_LEVEL;
      csr_data  <= seg;
      @(posedge clock);
      shadow.set_level(CSR_SEG_LEVEL, seg);
      csr_index <= CSR_DIGIT_LEVEL;
      csr_data  <= dig;
      @(posedge clock);
      shadow.set_level(CSR_DIGIT_LEVEL, dig);
      csr_write <= 1'b0;
   endtask

   // Hold until every owed result is out and items without results have drained
   task automatic settle();
      @(posedge clock);
      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly legal characters and dots, some unknown or arbitrary codes
   function automatic logic [7:0] pick_char();
      int pick;
      int idx;
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, 11);
      if (pick < 60) begin
         if (idx < 10) return CHAR_ZERO + 8'(idx);
         return (idx == 10) ? CHAR_MINUS : CHAR_SPACE;
      end
      if (pick < 80) return CHAR_DOT;
      return 8'($urandom_range(0, 255));
   endfunction

   // Strings with random content and scan ticks between them, plus loose noise
   task automatic run_random(input int stop_at);
      int len;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end else begin
            len = $urandom_range(0, 4);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 3) == 0)
                  send_item(FUNC_SCAN, 8'($urandom_range(0, 255)));
               send_item(FUNC_CHAR, pick_char());
            end
            send_item(FUNC_CHAR, CHAR_NUL);
            for (int k = $urandom_range(0, 3); k > 0; k--)
               send_item(FUNC_SCAN, 8'($urandom_range(0, 255)));
         end
      end
   endtask

   // Pop side: stall a random number of cycles before each result
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (rx_steady_left == 0) begin
            rx_steady      = ($urandom_range(0, 3) == 0);
            rx_steady_left = $urandom_range(20, 80);
         end
         rx_steady_left--;
         stall = rx_steady ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
      end
   end

   // Main sequence: reset, directed opening, then random phases at several levels
   initial begin
      logic [1:0] levels [5];
      levels = '{2'b00, 2'b11, 2'b01, 2'b10, 2'b00};
      levels[4] = 2'($urandom_range(0, 3));
      shadow = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_levels(1'b1, 1'b0);
      foreach (DIRECTED[i]) send_item(DIRECTED[i][8], DIRECTED[i][7:0]);
      push <= 1'b0;
      settle();
      for (int phase = 0; phase < 5; phase++) begin
         write_levels(levels[phase][1], levels[phase][0]);
         run_random(items_sent + PHASE_ITEMS);
         push <= 1'b0;
         settle();
      end
      if (shadow.errors == 0 && shadow.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== seven_segment_text_mux_driver.f =====
rtl/ssd_pkg.sv
rtl/ssd_front.sv
rtl/ssd_cmd_fifo.sv
rtl/ssd_back.sv
rtl/seven_segment_text_mux_driver.sv
sim/testbench.sv
